### sv/tcwd_pkg.sv
// ----------------------------------------------------------------------------
// tcwd_pkg : shared types and constants for the task check-in watchdog
// Slot count, field widths, operation codes, panic causes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tcwd_pkg;

    // Slot table size and derived widths
    localparam int SLOTS  = 8;
    localparam int SLOT_W = 3;                  // width of slot_index and slot numbers
    localparam int USED_W = $clog2(SLOTS + 1);  // fill count, may hold SLOTS itself

    // Field widths
    localparam int TICK_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int OP_W     = 3;
    localparam int CAUSE_W  = 2;

    // Stream payload widths (padded to whole bytes)
    localparam int S_TDATA_W = 40;              // slot_index, deadline_ticks
    localparam int M_TDATA_W = 16;              // result fields

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;

    // Operation codes carried on s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 3'd0,
        OP_REGISTER = 3'd1,
        OP_CHECKIN  = 3'd2,
        OP_SUSPEND  = 3'd3,
        OP_RESUME   = 3'd4,
        OP_START    = 3'd5,
        OP_PANIC    = 3'd6,
        OP_NOP      = 3'd7
    } opcode_t;

    // Latched panic cause
    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_TIMEOUT = 2'd1,
        CAUSE_REQUEST = 2'd2
    } cause_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_REBASE,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### sv/task_checkin_watchdog_unit.sv
// ----------------------------------------------------------------------------
// task_checkin_watchdog_unit : multi-task software watchdog monitor
// Keeps a tick counter and up to eight watched slots, scans them for overdue
// check-ins once per period and reports pet / panic status for every item.
// ----------------------------------------------------------------------------
// Usage
//   s_ channel: one operation per item. s_tuser[2:0] carries the opcode,
//   s_tdata carries slot_index [2:0] and deadline_ticks [34:3].
//   m_ channel: exactly one result item per input item, in order.
//   cfg_wr_en / cfg_wr_data write check_period; write only while idle.
// Sequencing
//   The block takes one item at a time; s_tready is high only when idle.
//   Most items pass through the execute and done states before the next
//   acceptance. A tick that ends a period while no panic is latched runs the
//   scan on one shared subtract and compare unit fed by the slot memories.
//   Start monitor rewrites the last-seen memory one slot a cycle, covering
//   every registered slot.
// Reset and stalls
//   Synchronous active-low reset clears the tick counter, slot count, period
//   counter and panic status; check_period returns to 100. Slot memories are
//   not cleared. A result waits in the output register while m_tready is
//   low; the next item is still taken and worked on, and only its own result
//   waits for the register to empty.
// ----------------------------------------------------------------------------
`default_nettype none

module task_checkin_watchdog_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Configuration: check_period
    input  wire logic                            cfg_wr_en,
    input  wire logic [tcwd_pkg::PERIOD_W-1:0]   cfg_wr_data,
    // Input items
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [2:0] slot_index, [34:3] deadline_ticks, [39:35] zero
    input  wire logic [tcwd_pkg::S_TDATA_W-1:0]  s_tdata,
    // [2:0] opcode
    input  wire logic [tcwd_pkg::OP_W-1:0]       s_tuser,
    // Result items
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [2:0] assigned_slot, [3] op_accepted, [4] pet_pulse, [5] panicked,
    // [7:6] panic_cause, [10:8] late_slot, [11] late_valid, [15:12] zero
    output logic [tcwd_pkg::M_TDATA_W-1:0]       m_tdata
);

    // Control state
    tcwd_pkg::state_t                 state_reg,   state_next;
    logic [tcwd_pkg::TICK_W-1:0]      tick_reg,    tick_next;
    logic [tcwd_pkg::USED_W-1:0]      used_reg,    used_next;
    logic [tcwd_pkg::PERIOD_W-1:0]    period_reg,  period_next;
    logic [tcwd_pkg::PERIOD_W-1:0]    check_period_reg, check_period_next;
    logic                             running_reg, running_next;
    logic                             panic_reg,   panic_next;
    tcwd_pkg::cause_t                 cause_reg,   cause_next;
    logic [tcwd_pkg::SLOT_W-1:0]      late_slot_reg, late_slot_next;
    logic                             late_valid_reg, late_valid_next;
    logic                             m_valid_reg, m_valid_next;

    // Item and result payload
    tcwd_pkg::opcode_t                op_reg,      op_next;
    logic [tcwd_pkg::SLOT_W-1:0]      idx_reg,     idx_next;
    logic [tcwd_pkg::TICK_W-1:0]      dl_reg,      dl_next;
    logic [tcwd_pkg::USED_W-1:0]      scan_idx_reg, scan_idx_next;
    logic [tcwd_pkg::SLOT_W-1:0]      assigned_reg, assigned_next;
    logic                             acc_reg,     acc_next;
    logic                             pet_reg,     pet_next;
    logic [tcwd_pkg::M_TDATA_W-1:0]   m_data_reg,  m_data_next;

    // Slot storage
    logic [tcwd_pkg::TICK_W-1:0]      slot_deadline_mem  [tcwd_pkg::SLOTS];
    logic [tcwd_pkg::TICK_W-1:0]      slot_last_seen_mem [tcwd_pkg::SLOTS];
    logic [tcwd_pkg::SLOTS-1:0]       susp_reg;
    logic [tcwd_pkg::TICK_W-1:0]      dl_rd_reg;
    logic [tcwd_pkg::TICK_W-1:0]      ls_rd_reg;

    // Memory write controls
    logic                             ls_we;
    logic                             dl_we;
    logic                             susp_we;
    logic                             susp_wval;
    logic [tcwd_pkg::SLOT_W-1:0]      mem_waddr;

    // Shared arithmetic
    logic [tcwd_pkg::PERIOD_W-1:0]    period_inc;
    logic [tcwd_pkg::TICK_W-1:0]      elapsed;
    logic                             idx_ok;
    logic [tcwd_pkg::SLOT_W-1:0]      scan_slot;

    assign s_tready   = (state_reg == tcwd_pkg::ST_IDLE);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;

    assign period_inc = period_reg + tcwd_pkg::PERIOD_W'(1);
    assign scan_slot  = scan_idx_reg[tcwd_pkg::SLOT_W-1:0];
    assign elapsed    = tick_reg - ls_rd_reg;
    assign idx_ok     = (tcwd_pkg::USED_W'(idx_reg) < used_reg);

    // Sequencer: next state, status updates and memory writes
    always_comb begin
        state_next        = state_reg;
        tick_next         = tick_reg;
        used_next         = used_reg;
        period_next       = period_reg;
        check_period_next = cfg_wr_en ? cfg_wr_data : check_period_reg;
        running_next      = running_reg;
        panic_next        = panic_reg;
        cause_next        = cause_reg;
        late_slot_next    = late_slot_reg;
        late_valid_next   = late_valid_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        m_data_next       = m_data_reg;
        op_next           = op_reg;
        idx_next          = idx_reg;
        dl_next           = dl_reg;
        scan_idx_next     = scan_idx_reg;
        assigned_next     = assigned_reg;
        acc_next          = acc_reg;
        pet_next          = pet_reg;
        ls_we             = 1'b0;
        dl_we             = 1'b0;
        susp_we           = 1'b0;
        susp_wval         = 1'b0;
        mem_waddr         = idx_reg;

        case (state_reg)
            tcwd_pkg::ST_IDLE: begin
                // Take the next item
                if (s_tvalid) begin
                    op_next       = tcwd_pkg::opcode_t'(s_tuser);
                    idx_next      = s_tdata[tcwd_pkg::SLOT_W-1:0];
                    dl_next       = s_tdata[tcwd_pkg::SLOT_W +: tcwd_pkg::TICK_W];
                    assigned_next = '0;
                    acc_next      = 1'b0;
                    pet_next      = 1'b0;
                    state_next    = tcwd_pkg::ST_EXEC;
                end
            end

            tcwd_pkg::ST_EXEC: begin
                state_next = tcwd_pkg::ST_DONE;
                case (op_reg)
                    tcwd_pkg::OP_TICK: begin
                        // Advance time, then the period counter
                        tick_next = tick_reg + tcwd_pkg::TICK_W'(1);
                        if (running_reg) begin
                            if (period_inc >= check_period_reg) begin
                                period_next = '0;
                                if (!panic_reg) begin
                                    scan_idx_next = '0;
                                    state_next    = tcwd_pkg::ST_SCAN_RD;
                                end
                            end else begin
                                period_next = period_inc;
                            end
                        end
                    end
                    tcwd_pkg::OP_REGISTER: begin
                        // Hand out the next free slot
                        if (used_reg < tcwd_pkg::USED_W'(tcwd_pkg::SLOTS)) begin
                            mem_waddr     = used_reg[tcwd_pkg::SLOT_W-1:0];
                            dl_we         = 1'b1;
                            ls_we         = 1'b1;
                            susp_we       = 1'b1;
                            susp_wval     = 1'b0;
                            assigned_next = used_reg[tcwd_pkg::SLOT_W-1:0];
                            acc_next      = 1'b1;
                            used_next     = used_reg + tcwd_pkg::USED_W'(1);
                        end
                    end
                    tcwd_pkg::OP_CHECKIN: begin
                        if (idx_ok) begin
                            ls_we    = 1'b1;
                            acc_next = 1'b1;
                        end
                    end
                    tcwd_pkg::OP_SUSPEND: begin
                        if (idx_ok) begin
                            susp_we   = 1'b1;
                            susp_wval = 1'b1;
                            acc_next  = 1'b1;
                        end
                    end
                    tcwd_pkg::OP_RESUME: begin
                        if (idx_ok) begin
                            ls_we     = 1'b1;
                            susp_we   = 1'b1;
                            susp_wval = 1'b0;
                            acc_next  = 1'b1;
                        end
                    end
                    tcwd_pkg::OP_START: begin
                        // Rebase every used slot, one a cycle
                        running_next  = 1'b1;
                        period_next   = '0;
                        scan_idx_next = '0;
                        if (used_reg != '0) begin
                            state_next = tcwd_pkg::ST_REBASE;
                        end
                    end
                    tcwd_pkg::OP_PANIC: begin
                        if (!panic_reg) begin
                            panic_next = 1'b1;
                            cause_next = tcwd_pkg::CAUSE_REQUEST;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            tcwd_pkg::ST_SCAN_RD: begin
                // Memories read this slot at the clock edge
                if (scan_idx_reg >= used_reg) begin
                    pet_next   = 1'b1;
                    state_next = tcwd_pkg::ST_DONE;
                end else begin
                    state_next = tcwd_pkg::ST_SCAN_CMP;
                end
            end

            tcwd_pkg::ST_SCAN_CMP: begin
                // Wrap-safe overdue test; first overdue slot ends the scan
                if (!susp_reg[scan_slot] && (elapsed > dl_rd_reg)) begin
                    late_slot_next  = scan_slot;
                    late_valid_next = 1'b1;
                    panic_next      = 1'b1;
                    cause_next      = tcwd_pkg::CAUSE_TIMEOUT;
                    state_next      = tcwd_pkg::ST_DONE;
                end else begin
                    scan_idx_next = scan_idx_reg + tcwd_pkg::USED_W'(1);
                    state_next    = tcwd_pkg::ST_SCAN_RD;
                end
            end

            tcwd_pkg::ST_REBASE: begin
                mem_waddr     = scan_slot;
                ls_we         = 1'b1;
                scan_idx_next = scan_idx_reg + tcwd_pkg::USED_W'(1);
                if (scan_idx_next == used_reg) begin
                    state_next = tcwd_pkg::ST_DONE;
                end
            end

            tcwd_pkg::ST_DONE: begin
                // Hand the result to the output register once it is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0000, late_valid_reg, late_slot_reg, cause_reg,
                                    panic_reg, pet_reg, acc_reg, assigned_reg};
                    state_next   = tcwd_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = tcwd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= tcwd_pkg::ST_IDLE;
            tick_reg         <= '0;
            used_reg         <= '0;
            period_reg       <= '0;
            check_period_reg <= tcwd_pkg::PERIOD_RESET;
            running_reg      <= 1'b0;
            panic_reg        <= 1'b0;
            cause_reg        <= tcwd_pkg::CAUSE_NONE;
            late_slot_reg    <= '0;
            late_valid_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            tick_reg         <= tick_next;
            used_reg         <= used_next;
            period_reg       <= period_next;
            check_period_reg <= check_period_next;
            running_reg      <= running_next;
            panic_reg        <= panic_next;
            cause_reg        <= cause_next;
            late_slot_reg    <= late_slot_next;
            late_valid_reg   <= late_valid_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        dl_reg       <= dl_next;
        scan_idx_reg <= scan_idx_next;
        assigned_reg <= assigned_next;
        acc_reg      <= acc_next;
        pet_reg      <= pet_next;
        m_data_reg   <= m_data_next;
    end

    // Slot memories: one write port, one registered read at the scan slot
    always_ff @(posedge aclk) begin
        if (dl_we) begin
            slot_deadline_mem[mem_waddr] <= dl_reg;
        end
        if (ls_we) begin
            slot_last_seen_mem[mem_waddr] <= tick_reg;
        end
        if (susp_we) begin
            susp_reg[mem_waddr] <= susp_wval;
        end
        dl_rd_reg <= slot_deadline_mem[scan_slot];
        ls_rd_reg <= slot_last_seen_mem[scan_slot];
    end

endmodule

`default_nettype wire

### sv/tcwd_checker.sv
// ----------------------------------------------------------------------------
// tcwd_checker : port-level checks for the task check-in watchdog
// Watches the stream ports of the top level and flags broken behaviour.
// ----------------------------------------------------------------------------
`default_nettype none

module tcwd_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [tcwd_pkg::M_TDATA_W-1:0]  m_tdata
);

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Drop ready in the cycle after taking an item
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while previous one in progress");

    // A named overdue slot implies a latched timeout panic
    a_late_implies_timeout: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[11] |-> m_tdata[5] && (m_tdata[7:6] == tcwd_pkg::CAUSE_TIMEOUT))
        else $error("overdue slot without timeout panic");

    // Never pet while panic is latched
    a_no_pet_in_panic: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5] |-> !m_tdata[4])
        else $error("pet pulse while panicked");

    // Output empty after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind task_checkin_watchdog_unit tcwd_checker u_tcwd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
